@@ hdl/fsa_pkg.sv @@
package fsa_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int POOL_BYTES = 65536;

	localparam logic [1:0] STRAT_FIRST = 2'd0;
	localparam logic [1:0] STRAT_BEST  = 2'd1;
	localparam logic [1:0] STRAT_WORST = 2'd2;
	localparam logic [1:0] STRAT_NEXT  = 2'd3;

	localparam logic CFG_STRATEGY  = 1'b0;
	localparam logic CFG_POOL_SIZE = 1'b1;

	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_FREE   = 2'd1;
	localparam logic [1:0] REQ_REINIT = 2'd2;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_FIT   = 3'd1,
		ST_FULL     = 3'd2,
		ST_BAD_ADDR = 3'd3,
		ST_ZERO     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_ZERO,
		OP_FREE,
		OP_REINIT,
		OP_NOP
	} op_t;

	typedef enum logic [3:0] {
		B_INIT,
		B_IDLE,
		B_SCAN,
		B_DECIDE,
		B_MOVE,
		B_FIX1,
		B_FIX2,
		B_STATS,
		B_DONE
	} bstate_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [16:0] request_bytes;
		logic [15:0] free_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] address;
		logic [16:0] free_bytes;
		logic [16:0] allocated_bytes;
		logic [6:0]  hole_count;
		logic [16:0] largest_free;
	} res_t;

	typedef struct packed {
		op_t         op;
		logic [16:0] bytes;
		logic [15:0] addr;
	} cmd_t;

	typedef struct packed {
		logic [15:0] off;
		logic [16:0] size;
		logic        used;
	} seg_t;

endpackage

@@ hdl/fit_strategy_segment_allocator.sv @@
// A split or merge shifts the table entries above the segment; a rejected request and a reinit shift none.
// One request is worked at a time; the segment table memory, one read and one write a cycle,
// sets the pace. A two-entry queue takes new requests while one is in work or a result waits.
// Reset is asynchronous, active low; the cycle after reset writes the single pool segment.
module fit_strategy_segment_allocator
	import fsa_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_wdata
);

	logic [1:0]  strategy_q;
	logic [16:0] pool_size_q;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q  <= STRAT_FIRST;
			pool_size_q <= 17'(POOL_BYTES);
		end else if (cfg_we) begin
			if (cfg_index == CFG_STRATEGY) strategy_q <= cfg_wdata[1:0];
			else pool_size_q <= cfg_wdata;
		end
	end

	fsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	fsa_back #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.strategy  (strategy_q),
		.pool_size (pool_size_q),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (out_data)
	);

endmodule

@@ hdl/fsa_front.sv @@
module fsa_front
	import fsa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic cmd_valid,
	input  logic cmd_ready,
	output cmd_t cmd
);

	cmd_t       slot_q [2];
	logic [1:0] fill_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.bytes = in_data.request_bytes;
		cls.addr  = in_data.free_address;
		unique case (in_data.req_type)
			REQ_ALLOC:  cls.op = (in_data.request_bytes == '0) ? OP_ZERO : OP_ALLOC;
			REQ_FREE:   cls.op = OP_FREE;
			REQ_REINIT: cls.op = OP_REINIT;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign in_ready  = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = cmd_valid & cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cls;
	end

endmodule

@@ hdl/fsa_back.sv @@
module fsa_back
	import fsa_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic [1:0]  strategy,
	input  logic [16:0] pool_size,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	seg_t          mem [MAX_SEGMENTS];
	seg_t          rd_q;
	logic [IW-1:0] rd_addr;
	logic          mem_we;
	logic [IW-1:0] wa;
	seg_t          wd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[wa] <= wd;
		rd_q <= mem[rd_addr];
	end

	bstate_t       state_q, state_d;
	op_t           op_q;
	logic [16:0]   req_q;
	logic [15:0]   fa_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] cur_q;
	status_t       status_q;
	logic [15:0]   addr_q;

	logic [CW-1:0] scan_idx_q;
	logic          rv_s1;
	logic [IW-1:0] ri_s1;
	logic          issue;

	logic          a_found_q, g_found_q;
	logic [IW-1:0] a_idx_q, g_idx_q;
	seg_t          a_seg_q, g_seg_q;

	logic          m_found_q, n_has_q, n_want_q;
	logic [IW-1:0] m_idx_q;
	seg_t          m_seg_q, p_seg_q, n_seg_q, last_seg_q;

	logic [IW-1:0] mv_src_q;
	logic [CW-1:0] mv_left_q;
	logic          mv_up_q;
	logic [1:0]    mv_k_q;
	logic          mv_pend_s1;
	logic [IW-1:0] mv_dst_s1;
	logic          mv_issue;

	logic [IW-1:0] f1_a_q, f2_a_q;
	seg_t          f1_d_q, f2_d_q;
	logic          f2_on_q;

	logic [16:0]   fb_q, ab_q, lg_q;
	logic [6:0]    hc_q;

	logic          res_valid_q;
	res_t          res_q;

	// pick and merge decode
	logic          use_g;
	logic [IW-1:0] pk_idx;
	seg_t          pk_seg;
	logic          pm, nm, free_ok;
	logic [CW-1:0] start;
	logic [16:0]   pool_eff;

	function automatic logic [CW-1:0] absorb_cur(logic [CW-1:0] cur, logic [CW-1:0] k,
			logic [CW-1:0] c);
		logic [CW-1:0] r;
		if (cur == k) r = (k + CW'(1) < c) ? '0 : k - CW'(1);
		else if (cur > k) r = cur - CW'(1);
		else r = cur;
		return r;
	endfunction

	always_comb begin
		use_g   = (strategy == STRAT_NEXT) && g_found_q;
		pk_idx  = use_g ? g_idx_q : a_idx_q;
		pk_seg  = use_g ? g_seg_q : a_seg_q;
		pm      = (m_idx_q != '0) && !p_seg_q.used;
		nm      = n_has_q && !n_seg_q.used;
		free_ok = m_found_q && m_seg_q.used;
		start   = (CW'(cur_q) < cnt_q) ? CW'(cur_q) : '0;
		if (pool_size == '0) pool_eff = 17'd1;
		else if (pool_size > 17'(POOL_BYTES)) pool_eff = 17'(POOL_BYTES);
		else pool_eff = pool_size;
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		issue     = 1'b0;
		mv_issue  = 1'b0;
		rd_addr   = scan_idx_q[IW-1:0];
		mem_we    = 1'b0;
		wa        = f1_a_q;
		wd        = f1_d_q;
		unique case (state_q)
			B_INIT: begin
				mem_we   = 1'b1;
				wa       = '0;
				wd.off   = '0;
				wd.size  = 17'(POOL_BYTES);
				wd.used  = 1'b0;
				state_d  = B_IDLE;
			end
			B_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_ALLOC, OP_FREE: state_d = B_SCAN;
						OP_REINIT:         state_d = B_FIX1;
						default:           state_d = B_STATS;
					endcase
				end
			end
			B_SCAN, B_STATS: begin
				issue = (scan_idx_q < cnt_q);
				if (!issue && !rv_s1) state_d = (state_q == B_SCAN) ? B_DECIDE : B_DONE;
			end
			B_DECIDE: begin
				if (op_q == OP_ALLOC) begin
					if (!a_found_q) state_d = B_STATS;
					else if (pk_seg.size > req_q)
						state_d = (cnt_q >= CW'(MAX_SEGMENTS)) ? B_STATS : B_MOVE;
					else state_d = B_FIX1;
				end else begin
					if (!free_ok) state_d = B_STATS;
					else if (pm || nm) state_d = B_MOVE;
					else state_d = B_FIX1;
				end
			end
			B_MOVE: begin
				mv_issue = (mv_left_q != '0);
				rd_addr  = mv_src_q;
				mem_we   = mv_pend_s1;
				wa       = mv_dst_s1;
				wd       = rd_q;
				if (!mv_issue && !mv_pend_s1) state_d = B_FIX1;
			end
			B_FIX1: begin
				mem_we  = 1'b1;
				state_d = f2_on_q ? B_FIX2 : B_STATS;
			end
			B_FIX2: begin
				mem_we  = 1'b1;
				wa      = f2_a_q;
				wd      = f2_d_q;
				state_d = B_STATS;
			end
			B_DONE: begin
				if (!res_valid_q || res_ready) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_INIT;
			cnt_q       <= CW'(1);
			cur_q       <= '0;
			rv_s1       <= 1'b0;
			mv_pend_s1  <= 1'b0;
			mv_left_q   <= '0;
			scan_idx_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rv_s1      <= issue;
			mv_pend_s1 <= mv_issue;
			if (state_d != state_q && (state_d == B_SCAN || state_d == B_STATS))
				scan_idx_q <= '0;
			else if (issue)
				scan_idx_q <= scan_idx_q + CW'(1);
			if (mv_issue) mv_left_q <= mv_left_q - CW'(1);
			if (state_q == B_IDLE && cmd_valid && cmd.op == OP_REINIT) begin
				cnt_q <= CW'(1);
				cur_q <= '0;
			end
			if (state_q == B_DECIDE && op_q == OP_ALLOC && a_found_q) begin
				if (pk_seg.size > req_q) begin
					if (cnt_q < CW'(MAX_SEGMENTS)) begin
						cnt_q     <= cnt_q + CW'(1);
						cur_q     <= IW'(CW'(pk_idx) + CW'(1));
						mv_left_q <= cnt_q - CW'(pk_idx) - CW'(1);
					end
				end else begin
					cur_q <= (CW'(pk_idx) + CW'(1) >= cnt_q) ? '0 : pk_idx;
				end
			end
			if (state_q == B_DECIDE && op_q == OP_FREE && free_ok && (pm || nm)) begin
				cnt_q     <= cnt_q - ((pm && nm) ? CW'(2) : CW'(1));
				// entries above the merged run move down
				mv_left_q <= cnt_q - CW'(m_idx_q) - CW'(1) - (nm ? CW'(1) : CW'(0));
				if (pm) begin
					if (nm)
						cur_q <= IW'(absorb_cur(absorb_cur(CW'(cur_q), CW'(m_idx_q), cnt_q),
							CW'(m_idx_q), cnt_q - CW'(1)));
					else
						cur_q <= IW'(absorb_cur(CW'(cur_q), CW'(m_idx_q), cnt_q));
				end else begin
					cur_q <= IW'(absorb_cur(CW'(cur_q), CW'(m_idx_q) + CW'(1), cnt_q));
				end
			end
			if (state_q == B_DONE && state_d == B_IDLE) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		ri_s1     <= scan_idx_q[IW-1:0];
		mv_dst_s1 <= mv_up_q ? mv_src_q + IW'(1) : mv_src_q - IW'(mv_k_q);
		if (mv_issue) mv_src_q <= mv_up_q ? mv_src_q - IW'(1) : mv_src_q + IW'(1);

		if (state_q == B_IDLE && cmd_valid) begin
			op_q     <= cmd.op;
			req_q    <= cmd.bytes;
			fa_q     <= cmd.addr;
			status_q <= (cmd.op == OP_ZERO) ? ST_ZERO : ST_OK;
			addr_q   <= (cmd.op == OP_FREE) ? cmd.addr : '0;
			f2_on_q  <= 1'b0;
			f1_a_q   <= '0;
			f1_d_q   <= '{off: '0, size: pool_eff, used: 1'b0};
		end

		if (state_d == B_SCAN && state_q != B_SCAN) begin
			a_found_q <= 1'b0;
			g_found_q <= 1'b0;
			m_found_q <= 1'b0;
			n_has_q   <= 1'b0;
			n_want_q  <= 1'b0;
		end else if (state_q == B_SCAN && rv_s1) begin
			last_seg_q <= rd_q;
			if (!rd_q.used && rd_q.size >= req_q) begin
				if (!a_found_q || (strategy == STRAT_BEST && rd_q.size < a_seg_q.size) ||
						(strategy == STRAT_WORST && rd_q.size > a_seg_q.size)) begin
					a_found_q <= 1'b1;
					a_idx_q   <= ri_s1;
					a_seg_q   <= rd_q;
				end
				if (!g_found_q && CW'(ri_s1) >= start) begin
					g_found_q <= 1'b1;
					g_idx_q   <= ri_s1;
					g_seg_q   <= rd_q;
				end
			end
			if (!m_found_q && rd_q.off == fa_q) begin
				m_found_q <= 1'b1;
				m_idx_q   <= ri_s1;
				m_seg_q   <= rd_q;
				p_seg_q   <= last_seg_q;
				n_want_q  <= 1'b1;
			end else if (n_want_q) begin
				n_seg_q  <= rd_q;
				n_has_q  <= 1'b1;
				n_want_q <= 1'b0;
			end
		end

		if (state_q == B_DECIDE) begin
			if (op_q == OP_ALLOC) begin
				if (!a_found_q) status_q <= ST_NO_FIT;
				else if (pk_seg.size > req_q && cnt_q >= CW'(MAX_SEGMENTS)) status_q <= ST_FULL;
				else addr_q <= pk_seg.off;
				// split: shift the tail up, then leftover and used part
				mv_up_q  <= 1'b1;
				mv_src_q <= IW'(cnt_q - CW'(1));
				if (pk_seg.size > req_q) begin
					f1_a_q  <= pk_idx + IW'(1);
					f1_d_q  <= '{off: pk_seg.off + req_q[15:0], size: pk_seg.size - req_q,
						used: 1'b0};
					f2_on_q <= 1'b1;
					f2_a_q  <= pk_idx;
					f2_d_q  <= '{off: pk_seg.off, size: req_q, used: 1'b1};
				end else begin
					f1_a_q <= pk_idx;
					f1_d_q <= '{off: pk_seg.off, size: pk_seg.size, used: 1'b1};
				end
			end else begin
				if (!free_ok) status_q <= ST_BAD_ADDR;
				mv_up_q <= 1'b0;
				mv_k_q  <= (pm && nm) ? 2'd2 : 2'd1;
				if (pm) begin
					mv_src_q <= m_idx_q + ((nm) ? IW'(2) : IW'(1));
					f1_a_q   <= m_idx_q - IW'(1);
					f1_d_q   <= '{off: p_seg_q.off,
						size: p_seg_q.size + m_seg_q.size + (nm ? n_seg_q.size : 17'd0),
						used: 1'b0};
				end else begin
					mv_src_q <= m_idx_q + IW'(2);
					f1_a_q   <= m_idx_q;
					f1_d_q   <= '{off: m_seg_q.off,
						size: m_seg_q.size + (nm ? n_seg_q.size : 17'd0), used: 1'b0};
				end
			end
		end

		if (state_d == B_STATS && state_q != B_STATS) begin
			fb_q <= '0;
			ab_q <= '0;
			lg_q <= '0;
			hc_q <= '0;
		end else if (state_q == B_STATS && rv_s1) begin
			if (rd_q.used) begin
				ab_q <= ab_q + rd_q.size;
			end else begin
				fb_q <= fb_q + rd_q.size;
				hc_q <= hc_q + 7'd1;
				if (rd_q.size > lg_q) lg_q <= rd_q.size;
			end
		end

		if (state_q == B_DONE && state_d == B_IDLE) begin
			res_q.status          <= status_q;
			res_q.address         <= addr_q;
			res_q.free_bytes      <= fb_q;
			res_q.allocated_bytes <= ab_q;
			res_q.hole_count      <= hc_q;
			res_q.largest_free    <= lg_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ hdl/fsa_checker.sv @@
module fsa_checker
	import fsa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input res_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_pool_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_data.free_bytes} + {1'b0, out_data.allocated_bytes})
			<= 18'(POOL_BYTES))
		else $error("free plus allocated exceeds pool");

	a_largest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.largest_free <= out_data.free_bytes)
		else $error("largest hole above free total");

	a_holes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.hole_count == '0) == (out_data.largest_free == '0)))
		else $error("hole count and largest hole disagree");

endmodule

bind fit_strategy_segment_allocator fsa_checker u_fsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
